// ===== design/stk500v1_command_parser_assert.svh =====
// Assertion macros for the STK500v1 command parser.
// Used by the top level only; no other dependency.
`ifndef STK500V1_COMMAND_PARSER_ASSERT_SVH
`define STK500V1_COMMAND_PARSER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define STK_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define STK_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define STK_ASSERT_IMPL(label, clk, rst_n, prop)
`define STK_ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== design/stk_pkg.sv =====
// Shared types and constants for the STK500v1 command parser.
// No dependencies.
package stk_pkg;
  localparam int unsigned PageBytesDefault = 512;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [2:0] {
    PH_IDLE, PH_ARGS, PH_EOP, PH_PHDR, PH_PDATA, PH_RHDR
  } phase_e;

  typedef enum logic [1:0] {FIN_NONE, FIN_PROG, FIN_READ} fin_e;

  // Job classes handed from the parser to the reply sequencer
  typedef enum logic [3:0] {
    J_NONE, J_STAGE, J_NOSYNC, J_OK, J_SIGNON, J_PARAM, J_LEAVE,
    J_UNIV, J_SIG, J_COMMIT, J_READ
  } job_e;

  typedef enum logic [2:0] {
    K_TX = 3'd0, K_STAGE = 3'd1, K_COMMIT = 3'd2, K_READ = 3'd3, K_LEAVE = 3'd4
  } kind_e;

  localparam logic [7:0] CmdSync = 8'h30, CmdSignOn = 8'h31, CmdSetParm = 8'h40,
    CmdGetParm = 8'h41, CmdSetDev = 8'h42, CmdSetDevExt = 8'h45,
    CmdEnter = 8'h50, CmdLeave = 8'h51, CmdErase = 8'h52, CmdLoadAddr = 8'h55,
    CmdUniv = 8'h56, CmdProgPage = 8'h64, CmdReadPage = 8'h74, CmdReadSig = 8'h75;
  localparam logic [7:0] EopByte = 8'h20, InsyncByte = 8'h14, OkByte = 8'h10,
    NosyncByte = 8'h15;

  typedef struct packed {
    job_e        job;
    logic [7:0]  data;    // staged byte or get-parameter value
    logic [8:0]  offset;
    logic [15:0] addr;
    logic [9:0]  len;
    logic [1:0]  mem;
  } job_t;

  function automatic logic [7:0] sign_on_char(input logic [2:0] i);
    case (i)
      3'd0: sign_on_char = 8'h41;
      3'd1: sign_on_char = 8'h56;
      3'd2: sign_on_char = 8'h52;
      3'd3: sign_on_char = 8'h20;
      3'd4: sign_on_char = 8'h53;
      3'd5: sign_on_char = 8'h54;
      3'd6: sign_on_char = 8'h4B;
      default: sign_on_char = 8'h00;
    endcase
  endfunction
endpackage

// ===== design/stk_front.sv =====
// Front part: accepts link bytes, tracks the packet phase and issues at most one job per byte.
// Depends on stk_pkg.
module stk_front #(
  parameter int unsigned PageBytes = stk_pkg::PageBytesDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [7:0]     rx_byte_i,
  output stk_pkg::job_t  job_o
);
  stk_pkg::phase_e phase_q, phase_d;
  stk_pkg::fin_e   fin_q, fin_d;
  logic [7:0]  cmd_q, cmd_d, a0_q, a0_d, a1_q, a1_d, a2_q, a2_d, mem_q, mem_d;
  logic [15:0] addr_q, addr_d;
  logic [4:0]  left_q, left_d, idx_q, idx_d;
  logic [9:0]  size_q, size_d, pidx_q, pidx_d;
  logic [1:0]  mcode;
  logic [15:0] hsize;
  logic [9:0]  pidx_inc;
  stk_pkg::job_t job;

  always_comb begin
    if (mem_q == 8'h46 || mem_q == 8'h66) mcode = 2'd0;
    else if (mem_q == 8'h45 || mem_q == 8'h65) mcode = 2'd1;
    else mcode = 2'd2;
  end

  always_comb begin
    phase_d = phase_q; fin_d = fin_q; cmd_d = cmd_q;
    a0_d = a0_q; a1_d = a1_q; a2_d = a2_q; mem_d = mem_q; addr_d = addr_q;
    left_d = left_q; idx_d = idx_q; size_d = size_q; pidx_d = pidx_q;
    hsize = '0;
    pidx_inc = pidx_q + 10'd1;
    job = '0;
    job.job = stk_pkg::J_NONE;
    case (phase_q)
      stk_pkg::PH_ARGS, stk_pkg::PH_PHDR, stk_pkg::PH_RHDR: begin
        if (idx_q == 5'd0) a0_d = rx_byte_i;
        else if (idx_q == 5'd1) a1_d = rx_byte_i;
        else if (idx_q == 5'd2) a2_d = rx_byte_i;
        if (idx_q < 5'd31) idx_d = idx_q + 5'd1;
        if (left_q > 5'd0) left_d = left_q - 5'd1;
        if (left_d == 5'd0) begin
          if (phase_q == stk_pkg::PH_ARGS) begin
            phase_d = stk_pkg::PH_EOP;
          end else begin
            hsize = {a0_d, a1_d};
            size_d = hsize[9:0];
            mem_d = a2_d;
            fin_d = stk_pkg::FIN_NONE;
            phase_d = stk_pkg::PH_EOP;
            if (hsize <= 16'(PageBytes)) begin
              if (phase_q == stk_pkg::PH_PHDR) begin
                pidx_d = '0;
                if (hsize != 16'd0) phase_d = stk_pkg::PH_PDATA;
              end else begin
                fin_d = stk_pkg::FIN_READ;
              end
            end
          end
        end
      end
      stk_pkg::PH_EOP: begin
        job.addr = addr_q; job.len = size_q; job.mem = mcode;
        if (rx_byte_i != stk_pkg::EopByte) job.job = stk_pkg::J_NOSYNC;
        else if (fin_q == stk_pkg::FIN_PROG) job.job = stk_pkg::J_COMMIT;
        else if (fin_q == stk_pkg::FIN_READ) job.job = stk_pkg::J_READ;
        else begin
          case (cmd_q)
            stk_pkg::CmdSync, stk_pkg::CmdSetParm, stk_pkg::CmdSetDev,
            stk_pkg::CmdSetDevExt, stk_pkg::CmdEnter, stk_pkg::CmdErase:
              job.job = stk_pkg::J_OK;
            stk_pkg::CmdLoadAddr: begin
              job.job = stk_pkg::J_OK;
              addr_d = {a1_q, a0_q};
            end
            stk_pkg::CmdSignOn: job.job = stk_pkg::J_SIGNON;
            stk_pkg::CmdGetParm: begin
              job.job = stk_pkg::J_PARAM;
              if (a0_q == 8'h80) job.data = 8'd1;
              else if (a0_q == 8'h81) job.data = 8'd8;
              else if (a0_q == 8'h82) job.data = 8'd2;
              else job.data = 8'h03;
            end
            stk_pkg::CmdLeave: job.job = stk_pkg::J_LEAVE;
            stk_pkg::CmdUniv: job.job = stk_pkg::J_UNIV;
            stk_pkg::CmdReadSig: job.job = stk_pkg::J_SIG;
            default: job.job = stk_pkg::J_NOSYNC;
          endcase
        end
        fin_d = stk_pkg::FIN_NONE;
        phase_d = stk_pkg::PH_IDLE;
      end
      stk_pkg::PH_PDATA: begin
        job.job = stk_pkg::J_STAGE;
        job.data = rx_byte_i;
        job.offset = pidx_q[8:0];
        pidx_d = pidx_inc;
        if (pidx_inc >= size_q) begin
          fin_d = stk_pkg::FIN_PROG;
          phase_d = stk_pkg::PH_EOP;
        end
      end
      default: begin
        cmd_d = rx_byte_i;
        fin_d = stk_pkg::FIN_NONE;
        idx_d = '0;
        case (rx_byte_i)
          stk_pkg::CmdGetParm: begin left_d = 5'd1; phase_d = stk_pkg::PH_ARGS; end
          stk_pkg::CmdSetParm, stk_pkg::CmdLoadAddr: begin
            left_d = 5'd2; phase_d = stk_pkg::PH_ARGS;
          end
          stk_pkg::CmdSetDev: begin left_d = 5'd20; phase_d = stk_pkg::PH_ARGS; end
          stk_pkg::CmdSetDevExt: begin left_d = 5'd5; phase_d = stk_pkg::PH_ARGS; end
          stk_pkg::CmdUniv: begin left_d = 5'd4; phase_d = stk_pkg::PH_ARGS; end
          stk_pkg::CmdProgPage: begin left_d = 5'd3; phase_d = stk_pkg::PH_PHDR; end
          stk_pkg::CmdReadPage: begin left_d = 5'd3; phase_d = stk_pkg::PH_RHDR; end
          default: phase_d = stk_pkg::PH_EOP;
        endcase
      end
    endcase
  end

  assign job_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= stk_pkg::PH_IDLE; fin_q <= stk_pkg::FIN_NONE; cmd_q <= '0;
      a0_q <= '0; a1_q <= '0; a2_q <= '0; mem_q <= '0; addr_q <= '0;
      left_q <= '0; idx_q <= '0; size_q <= '0; pidx_q <= '0;
    end else if (valid_i) begin
      phase_q <= phase_d; fin_q <= fin_d; cmd_q <= cmd_d;
      a0_q <= a0_d; a1_q <= a1_d; a2_q <= a2_d; mem_q <= mem_d; addr_q <= addr_d;
      left_q <= left_d; idx_q <= idx_d; size_q <= size_d; pidx_q <= pidx_d;
    end
  end
endmodule

// ===== design/stk_queue.sv =====
// Short job queue between the parser and the reply sequencer.
// Depends on stk_pkg.
module stk_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  stk_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output stk_pkg::job_t data_o
);
  localparam int unsigned AW = $clog2(stk_pkg::QueueDepth);
  stk_pkg::job_t mem_q [stk_pkg::QueueDepth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign full_o  = cnt_q == (AW+1)'(stk_pkg::QueueDepth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + AW'(1);
      if (pop_i) rp_q <= rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end
endmodule

// ===== design/stk_back.sv =====
// Back part: expands one job into its result sequence, one result per cycle while ready_i is high.
// Depends on stk_pkg.
module stk_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  stk_pkg::job_t job_i,
  output logic          job_pop_o,
  input  logic [7:0]    sig0_i,
  input  logic [7:0]    sig1_i,
  input  logic [7:0]    sig2_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [2:0]    kind_o,
  output logic [7:0]    tx_data_o,
  output logic [8:0]    stage_offset_o,
  output logic [15:0]   mem_address_o,
  output logic [9:0]    page_length_o,
  output logic [1:0]    mem_kind_o,
  output logic          last_o
);
  logic [3:0] step_q, step_d, n_res;
  logic [2:0] kind;
  logic [7:0] data;
  logic       fire;

  always_comb begin
    kind = stk_pkg::K_TX;
    data = stk_pkg::OkByte;
    n_res = 4'd2;
    case (job_i.job)
      stk_pkg::J_STAGE: begin n_res = 4'd1; kind = stk_pkg::K_STAGE; data = job_i.data; end
      stk_pkg::J_NOSYNC: begin n_res = 4'd1; data = stk_pkg::NosyncByte; end
      stk_pkg::J_OK: if (step_q == 4'd0) data = stk_pkg::InsyncByte;
      stk_pkg::J_SIGNON: begin
        n_res = 4'd9;
        if (step_q == 4'd0) data = stk_pkg::InsyncByte;
        else if (step_q != 4'd8) data = stk_pkg::sign_on_char(3'(step_q - 4'd1));
      end
      stk_pkg::J_PARAM, stk_pkg::J_UNIV: begin
        n_res = 4'd3;
        if (step_q == 4'd0) data = stk_pkg::InsyncByte;
        else if (step_q == 4'd1) data = (job_i.job == stk_pkg::J_PARAM) ? job_i.data : 8'h00;
      end
      stk_pkg::J_SIG: begin
        n_res = 4'd5;
        case (step_q)
          4'd0: data = stk_pkg::InsyncByte;
          4'd1: data = sig0_i;
          4'd2: data = sig1_i;
          4'd3: data = sig2_i;
          default: data = stk_pkg::OkByte;
        endcase
      end
      stk_pkg::J_LEAVE: begin
        n_res = 4'd3;
        if (step_q == 4'd0) data = stk_pkg::InsyncByte;
        else if (step_q == 4'd2) begin kind = stk_pkg::K_LEAVE; data = 8'h00; end
      end
      stk_pkg::J_COMMIT: begin
        n_res = 4'd3;
        if (step_q == 4'd0) begin kind = stk_pkg::K_COMMIT; data = 8'h00; end
        else if (step_q == 4'd1) data = stk_pkg::InsyncByte;
      end
      stk_pkg::J_READ: begin
        n_res = 4'd3;
        if (step_q == 4'd0) data = stk_pkg::InsyncByte;
        else if (step_q == 4'd1) begin kind = stk_pkg::K_READ; data = 8'h00; end
      end
      default: n_res = 4'd1;
    endcase
  end

  // Output register with its own valid; refill on the transfer cycle
  logic        v_q;
  logic        load;
  logic        is_last;
  assign is_last = step_q == n_res - 4'd1;
  assign load = job_valid_i && (!v_q || ready_i);
  assign job_pop_o = load && is_last;
  assign step_d = is_last ? 4'd0 : step_q + 4'd1;
  assign fire = v_q && ready_i;

  logic [2:0]  kind_q;
  logic [7:0]  data_q;
  logic [8:0]  off_q;
  logic [15:0] addr_q;
  logic [9:0]  len_q;
  logic [1:0]  mem_q;
  logic        last_q;
  logic        addr_sel;
  assign addr_sel = kind == stk_pkg::K_COMMIT || kind == stk_pkg::K_READ;

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind; data_q <= data;
      off_q  <= (kind == stk_pkg::K_STAGE) ? job_i.offset : 9'd0;
      addr_q <= addr_sel ? job_i.addr : 16'd0;
      len_q  <= addr_sel ? job_i.len : 10'd0;
      mem_q  <= addr_sel ? job_i.mem : 2'd0;
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0; step_q <= '0;
    end else begin
      if (load) step_q <= step_d;
      if (load) v_q <= 1'b1;
      else if (fire) v_q <= 1'b0;
    end
  end

  assign valid_o = v_q;
  assign kind_o = kind_q;
  assign tx_data_o = data_q;
  assign stage_offset_o = off_q;
  assign mem_address_o = addr_q;
  assign page_length_o = len_q;
  assign mem_kind_o = mem_q;
  assign last_o = last_q;
endmodule

// ===== design/stk500v1_command_parser.sv =====
// Channel  | handshake           | payload
// rx       | rx_valid_i/rx_ready_o | rx_byte_i
// result   | res_valid_o/res_ready_i | kind_o .. last_o
// config   | cfg_we_i            | cfg_index_i, cfg_data_i
// A byte is taken while the job queue has room; the parser issues at most one job per byte
// into a 4-entry queue. The reply sequencer drains one result per cycle while res_ready_i
// is high; a job has up to nine results (sign-on). Reset clears control state, not the
// queue or result data; no clearing pass. Either side may stall; the queue decouples them.
// Top level; depends on stk_pkg, stk_front, stk_queue, stk_back and the assertion header.
`include "stk500v1_command_parser_assert.svh"
module stk500v1_command_parser #(
  parameter int unsigned PageBytes = stk_pkg::PageBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  tx_data_o,
  output logic [8:0]  stage_offset_o,
  output logic [15:0] mem_address_o,
  output logic [9:0]  page_length_o,
  output logic [1:0]  mem_kind_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  logic [7:0] sig0_q, sig1_q, sig2_q;
  stk_pkg::job_t job, qjob;
  logic full, empty, pop, acc, push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig0_q <= '0; sig1_q <= '0; sig2_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        2'd0: sig0_q <= cfg_data_i;
        2'd1: sig1_q <= cfg_data_i;
        2'd2: sig2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rx_ready_o = !full;
  assign acc = rx_valid_i && rx_ready_o;
  assign push = acc && job.job != stk_pkg::J_NONE;

  stk_front #(.PageBytes(PageBytes)) u_front (
    .clk_i, .rst_ni, .valid_i(acc), .rx_byte_i, .job_o(job)
  );

  stk_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(job), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(qjob)
  );

  stk_back u_back (
    .clk_i, .rst_ni, .job_valid_i(!empty), .job_i(qjob), .job_pop_o(pop),
    .sig0_i(sig0_q), .sig1_i(sig1_q), .sig2_i(sig2_q),
    .valid_o(res_valid_o), .ready_i(res_ready_i), .kind_o, .tx_data_o,
    .stage_offset_o, .mem_address_o, .page_length_o, .mem_kind_o, .last_o
  );

  `STK_ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, !(push && full && !pop))
  `STK_ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, !(pop && empty))
  `STK_ASSERT_IMPL(a_res_hold, clk_i, rst_ni,
    (res_valid_o && !res_ready_i) |=> (res_valid_o && $stable(kind_o) && $stable(tx_data_o)))
endmodule
